>>> design/wpf_pkg.sv
// Shared types, constants and arithmetic helpers for the weighted plane fit unit.
`default_nettype none

package wpf_pkg;

    localparam int COEF_FRAC_BITS_DEF = 32;
    localparam int THR_W              = 32;
    localparam logic [THR_W-1:0] THR_RESET = 32'd1;
    localparam int SHIFT_AB           = 8;
    localparam int SHIFT_C            = 12;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SRCH,
        OP_SKIP,
        OP_SWAP,
        OP_DLOAD,
        OP_DIV,
        OP_DFIN,
        OP_DWR,
        OP_MA,
        OP_MB,
        OP_MUL,
        OP_MFIN,
        OP_MSAT,
        OP_SUB,
        OP_ZERO,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] k;
        logic       first;
        logic       acc;
    } t_cmd;

    typedef struct packed {
        logic best_ok;
    } t_stat;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] sat64(input logic [63:0] m, input logic neg,
                                          input logic over);
        logic [63:0] res;
        if (neg) begin
            res = (over || m[63]) ? {1'b1, 63'd0} : (64'd0 - m);
        end else begin
            res = (over || m[63]) ? {1'b0, {63{1'b1}}} : m;
        end
        return res;
    endfunction

    function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] d;
        logic [63:0] res;
        d = {a[63], a} - {b[63], b};
        if (d[64] != d[63]) begin
            res = d[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            res = d[63:0];
        end
        return res;
    endfunction

    function automatic logic [63:0] shift_round64(input logic [63:0] v, input int s);
        logic [63:0] m;
        logic [63:0] r;
        m = mag64(v);
        r = (m >> s) + ((m >> (s - 1)) & 64'd1);
        return v[63] ? (64'd0 - r) : r;
    endfunction

endpackage

`default_nettype wire

>>> design/wpf_dp.sv
// Datapath: point accumulation, matrix registers, serial divider and split multiplier.
`default_nettype none

module wpf_dp #(
    parameter int COEF_FRAC_BITS = wpf_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire wpf_pkg::t_cmd         i_cmd,
    output wpf_pkg::t_stat             o_stat,
    input  wire logic                  i_cfg_we,
    input  wire logic [31:0]           i_cfg_wdata,
    input  wire logic signed [15:0]    i_x,
    input  wire logic signed [15:0]    i_y,
    input  wire logic signed [23:0]    i_o,
    input  wire logic [11:0]           i_w,
    output logic                       o_valid,
    output logic signed [63:0]         o_coef_a,
    output logic signed [63:0]         o_coef_b,
    output logic signed [63:0]         o_coef_c,
    output logic                       o_pivot_skipped
);
    import wpf_pkg::*;

    localparam logic [127:0] HALF = 128'd1 << (COEF_FRAC_BITS - 1);

    logic [THR_W-1:0]    r_thr;
    logic                r_v1;
    logic signed [15:0]  r_x, r_y;
    logic signed [28:0]  r_xw, r_yw;
    logic signed [36:0]  r_ow;
    logic [11:0]         r_w;
    logic [63:0]         r_sum [9];

    logic signed [44:0]  xxw, xyw, yyw;
    logic signed [52:0]  oxw, oyw;
    logic signed [28:0]  xw1, yw1;
    logic signed [36:0]  ow1;

    logic [63:0]  r_mat [3][4];
    logic [63:0]  rd;
    logic [63:0]  r_best;
    logic [1:0]   r_br;
    logic [63:0]  r_pv;
    logic         r_skip;

    logic [127:0] r_dq;
    logic [63:0]  r_rem, r_md;
    logic         r_neg;
    logic [63:0]  r_q;
    logic         r_over;
    logic [63:0]  r_ms;
    logic [63:0]  r_ma, r_mb;
    logic [127:0] r_prod;

    logic [63:0]  cand;
    logic         carry;
    logic [63:0]  rem2;
    logic         take;
    logic         rnd;
    logic [31:0]  a_h, b_h;
    logic [63:0]  pp;
    logic [6:0]   sh;
    logic [127:0] tsum;

    assign xw1 = i_x * $signed({1'b0, i_w});
    assign yw1 = i_y * $signed({1'b0, i_w});
    assign ow1 = i_o * $signed({1'b0, i_w});
    assign xxw = r_x * r_xw;
    assign xyw = r_y * r_xw;
    assign yyw = r_y * r_yw;
    assign oxw = r_x * r_ow;
    assign oyw = r_y * r_ow;

    assign rd    = r_mat[i_cmd.row][i_cmd.col];
    assign cand  = mag64(rd);
    assign carry = r_rem[63];
    assign rem2  = {r_rem[62:0], r_dq[127]};
    assign take  = carry || (rem2 >= r_md);
    assign rnd   = (r_rem >= (r_md - r_rem));
    assign a_h   = i_cmd.k[0] ? r_ma[63:32] : r_ma[31:0];
    assign b_h   = i_cmd.k[1] ? r_mb[63:32] : r_mb[31:0];
    assign pp    = a_h * b_h;
    assign sh    = 7'({1'b0, i_cmd.k[0]} + {1'b0, i_cmd.k[1]}) << 5;
    assign tsum  = r_prod + HALF;

    assign o_stat.best_ok = (r_best > 64'(r_thr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_x  <= i_x;
            r_y  <= i_y;
            r_xw <= xw1;
            r_yw <= yw1;
            r_ow <= ow1;
            r_w  <= i_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_v1 <= i_cmd.acc;
            if (i_cmd.op == OP_LOAD) begin
                for (int i = 0; i < 9; i++) begin
                    r_sum[i] <= '0;
                end
            end else if (r_v1) begin
                r_sum[0] <= r_sum[0] + 64'(xxw);
                r_sum[1] <= r_sum[1] + 64'(xyw);
                r_sum[2] <= r_sum[2] + 64'(r_xw);
                r_sum[3] <= r_sum[3] + 64'(yyw);
                r_sum[4] <= r_sum[4] + 64'(r_yw);
                r_sum[5] <= r_sum[5] + 64'(r_w);
                r_sum[6] <= r_sum[6] + 64'(oxw);
                r_sum[7] <= r_sum[7] + 64'(oyw);
                r_sum[8] <= r_sum[8] + 64'(r_ow);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (i_cmd.op == OP_OUT);
            if (i_cmd.op == OP_LOAD) begin
                r_skip <= 1'b0;
            end else if (i_cmd.op == OP_SKIP) begin
                r_skip <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_mat[0][0] <= r_sum[0]; r_mat[0][1] <= r_sum[1];
                r_mat[0][2] <= r_sum[2]; r_mat[0][3] <= r_sum[6];
                r_mat[1][0] <= r_sum[1]; r_mat[1][1] <= r_sum[3];
                r_mat[1][2] <= r_sum[4]; r_mat[1][3] <= r_sum[7];
                r_mat[2][0] <= r_sum[2]; r_mat[2][1] <= r_sum[4];
                r_mat[2][2] <= r_sum[5]; r_mat[2][3] <= r_sum[8];
            end
            OP_SRCH: begin
                if (i_cmd.first || (cand > r_best)) begin
                    r_best <= cand;
                    r_br   <= i_cmd.row;
                end
            end
            OP_SWAP: begin
                if (r_br != i_cmd.row) begin
                    for (int j = 0; j < 4; j++) begin
                        r_mat[i_cmd.row][j] <= r_mat[r_br][j];
                        r_mat[r_br][j]      <= r_mat[i_cmd.row][j];
                    end
                end
                r_pv <= r_mat[r_br][i_cmd.row];
            end
            OP_DLOAD: begin
                r_dq  <= 128'(mag64(rd)) << COEF_FRAC_BITS;
                r_md  <= mag64(r_pv);
                r_rem <= '0;
                r_neg <= rd[63] ^ r_pv[63];
            end
            OP_DIV: begin
                r_rem <= take ? (rem2 - r_md) : rem2;
                r_dq  <= {r_dq[126:0], take};
            end
            OP_DFIN: begin
                r_q    <= r_dq[63:0] + 64'(rnd);
                r_over <= (|r_dq[127:64]) || (rnd && (&r_dq[63:0]));
            end
            OP_DWR: begin
                r_mat[i_cmd.row][i_cmd.col] <= sat64(r_q, r_neg, r_over);
            end
            OP_MA: begin
                r_ma  <= cand;
                r_neg <= rd[63];
            end
            OP_MB: begin
                r_mb   <= cand;
                r_neg  <= r_neg ^ rd[63];
                r_prod <= '0;
            end
            OP_MUL: begin
                r_prod <= r_prod + (128'(pp) << sh);
            end
            OP_MFIN: begin
                r_q    <= tsum[COEF_FRAC_BITS+63:COEF_FRAC_BITS];
                r_over <= |tsum[127:COEF_FRAC_BITS+64];
            end
            OP_MSAT: begin
                r_ms <= sat64(r_q, r_neg, r_over);
            end
            OP_SUB: begin
                r_mat[i_cmd.row][i_cmd.col] <= sat_sub64(rd, r_ms);
            end
            OP_ZERO: begin
                r_mat[i_cmd.row][i_cmd.col] <= '0;
            end
            OP_OUT: begin
                o_coef_a        <= shift_round64(r_mat[0][3], SHIFT_AB);
                o_coef_b        <= shift_round64(r_mat[1][3], SHIFT_AB);
                o_coef_c        <= shift_round64(r_mat[2][3], SHIFT_C);
                o_pivot_skipped <= r_skip;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/wpf_ctrl.sv
// Controller: accumulation handshake and sequencing of the elimination steps.
`default_nettype none

module wpf_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_last,
    input  wire wpf_pkg::t_stat i_stat,
    output logic                o_busy,
    output wpf_pkg::t_cmd       o_cmd
);
    import wpf_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE  = 18'd1 << 0,
        S_DRAIN = 18'd1 << 1,
        S_LOAD  = 18'd1 << 2,
        S_SRCH  = 18'd1 << 3,
        S_DEC   = 18'd1 << 4,
        S_SWAP  = 18'd1 << 5,
        S_DLOAD = 18'd1 << 6,
        S_DIV   = 18'd1 << 7,
        S_DFIN  = 18'd1 << 8,
        S_DWR   = 18'd1 << 9,
        S_MA    = 18'd1 << 10,
        S_MB    = 18'd1 << 11,
        S_MUL   = 18'd1 << 12,
        S_MFIN  = 18'd1 << 13,
        S_MSAT  = 18'd1 << 14,
        S_SUB   = 18'd1 << 15,
        S_ZERO  = 18'd1 << 16,
        S_OUT   = 18'd1 << 17
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_p, n_p, r_r, n_r, r_c, n_c, r_k, n_k;
    logic [6:0] r_cnt, n_cnt;
    logic [2:0] nr;

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p     <= '0;
            r_r     <= '0;
            r_c     <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_r     <= n_r;
            r_c     <= n_c;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_r     = r_r;
        n_c     = r_c;
        n_k     = r_k;
        n_cnt   = r_cnt;
        o_cmd   = '{op: OP_NONE, row: r_p, col: r_c, k: r_k, first: 1'b0, acc: 1'b0};
        nr      = 3'({1'b0, r_r} + 3'd1);
        if (nr[1:0] == r_p) begin
            nr = nr + 3'd1;
        end
        unique case (r_state)
            S_IDLE: begin
                o_cmd.acc = i_start;
                if (i_start && i_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_p      = '0;
                n_r      = '0;
                n_state  = S_SRCH;
            end
            S_SRCH: begin
                o_cmd.op    = OP_SRCH;
                o_cmd.row   = r_r;
                o_cmd.col   = r_p;
                o_cmd.first = (r_r == r_p);
                if (r_r == 2'd2) begin
                    n_state = S_DEC;
                end else begin
                    n_r = r_r + 2'd1;
                end
            end
            S_DEC: begin
                if (i_stat.best_ok) begin
                    n_state = S_SWAP;
                end else begin
                    o_cmd.op = OP_SKIP;
                    if (r_p == 2'd2) begin
                        n_state = S_OUT;
                    end else begin
                        n_p     = r_p + 2'd1;
                        n_r     = r_p + 2'd1;
                        n_state = S_SRCH;
                    end
                end
            end
            S_SWAP: begin
                o_cmd.op = OP_SWAP;
                o_cmd.row = r_p;
                n_c      = r_p;
                n_state  = S_DLOAD;
            end
            S_DLOAD: begin
                o_cmd.op  = OP_DLOAD;
                o_cmd.row = r_p;
                o_cmd.col = r_c;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + 7'd1;
                if (&r_cnt) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                o_cmd.op = OP_DFIN;
                n_state  = S_DWR;
            end
            S_DWR: begin
                o_cmd.op  = OP_DWR;
                o_cmd.row = r_p;
                o_cmd.col = r_c;
                if (r_c == 2'd3) begin
                    n_r     = (r_p == 2'd0) ? 2'd1 : 2'd0;
                    n_c     = r_p + 2'd1;
                    n_state = S_MA;
                end else begin
                    n_c     = r_c + 2'd1;
                    n_state = S_DLOAD;
                end
            end
            S_MA: begin
                o_cmd.op  = OP_MA;
                o_cmd.row = r_p;
                o_cmd.col = r_c;
                n_state   = S_MB;
            end
            S_MB: begin
                o_cmd.op  = OP_MB;
                o_cmd.row = r_r;
                o_cmd.col = r_p;
                n_k       = '0;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                o_cmd.k  = r_k;
                n_k      = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = S_MFIN;
                end
            end
            S_MFIN: begin
                o_cmd.op = OP_MFIN;
                n_state  = S_MSAT;
            end
            S_MSAT: begin
                o_cmd.op = OP_MSAT;
                n_state  = S_SUB;
            end
            S_SUB: begin
                o_cmd.op  = OP_SUB;
                o_cmd.row = r_r;
                o_cmd.col = r_c;
                if (r_c == 2'd3) begin
                    n_state = S_ZERO;
                end else begin
                    n_c     = r_c + 2'd1;
                    n_state = S_MA;
                end
            end
            S_ZERO: begin
                o_cmd.op  = OP_ZERO;
                o_cmd.row = r_r;
                o_cmd.col = r_p;
                if (nr > 3'd2) begin
                    if (r_p == 2'd2) begin
                        n_state = S_OUT;
                    end else begin
                        n_p     = r_p + 2'd1;
                        n_r     = r_p + 2'd1;
                        n_state = S_SRCH;
                    end
                end else begin
                    n_r     = nr[1:0];
                    n_c     = r_p + 2'd1;
                    n_state = S_MA;
                end
            end
            S_OUT: begin
                o_cmd.op = OP_OUT;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/weighted_plane_fit_unit.sv
// Top level of the weighted least-squares plane fit unit.
// Points are taken one per cycle while busy is low; start with last high ends the set.
// Busy then stays high while the columns are searched and eliminated; when columns pivot,
// the time is set by the bit-serial divider, which runs once per pivot-row entry (nine
// entries at most), and by the multiply and subtract of each eliminated entry. The result
// appears for a single cycle with o_valid high, in the same cycle that busy falls,
// and the receiver cannot stall it.
`default_nettype none

module weighted_plane_fit_unit #(
    parameter int COEF_FRAC_BITS = wpf_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_cfg_we,
    input  wire logic [31:0]        i_cfg_wdata,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    input  wire logic signed [23:0] i_o,
    input  wire logic [11:0]        i_w,
    input  wire logic               i_last,
    output logic                    o_valid,
    output logic signed [63:0]      o_coef_a,
    output logic signed [63:0]      o_coef_b,
    output logic signed [63:0]      o_coef_c,
    output logic                    o_pivot_skipped
);
    import wpf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    wpf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_last),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    wpf_dp #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_x             (i_x),
        .i_y             (i_y),
        .i_o             (i_o),
        .i_w             (i_w),
        .o_valid         (o_valid),
        .o_coef_a        (o_coef_a),
        .o_coef_b        (o_coef_b),
        .o_coef_c        (o_coef_c),
        .o_pivot_skipped (o_pivot_skipped)
    );

endmodule

`default_nettype wire
